// ===== rtl/core/dqms_pkg.sv =====
// dqms_pkg: shared types, constants and saturation helpers for the dq motor step.
// No dependencies; used by dqms_mulq and dq_motor_model_step.
package dqms_pkg;

   typedef logic signed [47:0] s48_type;
   typedef logic signed [55:0] s56_type;

   localparam s48_type S48_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam s48_type S48_MIN = -48'sh7FFF_FFFF_FFFF - 48'sd1;

   localparam s48_type CUR_LIM = 48'sd1073741824;
   localparam s48_type TRQ_LIM = 48'sd268435456;
   localparam s48_type SPD_LIM = 48'sd68719476736;
   localparam s48_type ANG_LIM = 48'sd105414357;

   // 2*pi in Q.33
   localparam logic [63:0] TWO_PI_Q33 = 64'd53972150818;

   localparam logic [2:0] REG_TIME_STEP  = 3'd0;
   localparam logic [2:0] REG_INV_L      = 3'd1;
   localparam logic [2:0] REG_RESISTANCE = 3'd2;
   localparam logic [2:0] REG_POLE_PAIRS = 3'd3;
   localparam logic [2:0] REG_FLUX       = 3'd4;
   localparam logic [2:0] REG_INV_J      = 3'd5;
   localparam logic [2:0] REG_LOAD       = 3'd6;
   localparam logic [2:0] REG_INV_KR     = 3'd7;

   function automatic s48_type sat48(input s56_type v);
      s48_type r;
      if (v > s56_type'(S48_MAX))
         r = S48_MAX;
      else if (v < s56_type'(S48_MIN))
         r = S48_MIN;
      else
         r = v[47:0];
      return r;
   endfunction

   function automatic s48_type clamp_sym(input s48_type v, input s48_type lim);
      s48_type r;
      if (v > lim)
         r = lim;
      else if (v < -lim)
         r = -lim;
      else
         r = v;
      return r;
   endfunction

endpackage

// ===== rtl/core/dqms_mulq.sv =====
// dqms_mulq: sequential Q-format multiplier, (a*b) >> FRAC_BITS floored, saturated.
// Four 24x24 partial products accumulated in sequence; uses dqms_pkg.
module dqms_mulq #(
   parameter int FRAC_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dqms_pkg::s48_type a,
   input  dqms_pkg::s48_type b,
   output logic              done,
   output dqms_pkg::s48_type result
);

   logic [47:0] ua_ff, ub_ff;
   logic        neg_ff;
   logic [95:0] acc_ff;
   logic [1:0]  cnt_ff;
   logic        busy_ff, fin_ff, done_ff;
   dqms_pkg::s48_type res_ff;

   logic [23:0] pa, pb;
   logic [47:0] pp;
   logic [95:0] pp_sh;
   logic [95:0] qv;
   logic [96:0] qn;
   logic        rem;
   dqms_pkg::s48_type fin_val;

   always_comb begin
      pa = cnt_ff[1] ? ua_ff[47:24] : ua_ff[23:0];
      pb = cnt_ff[0] ? ub_ff[47:24] : ub_ff[23:0];
      pp = pa * pb;
      case (2'(cnt_ff[1] + cnt_ff[0]))
         2'd0:    pp_sh = {48'd0, pp};
         2'd1:    pp_sh = {24'd0, pp, 24'd0};
         default: pp_sh = {pp, 48'd0};
      endcase
   end

   always_comb begin
      qv  = acc_ff >> FRAC_BITS;
      rem = |acc_ff[FRAC_BITS-1:0];
      qn  = {1'b0, qv} + 97'(neg_ff & rem);
      if (neg_ff) begin
         if (qn > 97'h8000_0000_0000)
            fin_val = dqms_pkg::S48_MIN;
         else
            fin_val = -$signed(qn[47:0]);
      end else begin
         if (qn > 97'h7FFF_FFFF_FFFF)
            fin_val = dqms_pkg::S48_MAX;
         else
            fin_val = $signed(qn[47:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= fin_ff & ~start & ~busy_ff;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ua_ff  <= a[47] ? (~a + 48'd1) : a;
         ub_ff  <= b[47] ? (~b + 48'd1) : b;
         neg_ff <= a[47] ^ b[47];
         acc_ff <= 96'd0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + pp_sh;
      end
      if (fin_ff)
         res_ff <= fin_val;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== rtl/core/dq_motor_model_step.sv =====
// dq_motor_model_step: one forward-Euler step of a dq-axis motor model per word.
// Uses dqms_pkg and the shared multiplier dqms_mulq.
//
//  channel  dir  handshake              payload
//  req_     in   tvalid/tready          tdata[29:0] voltage_amplitude
//  rsp_     out  tvalid/tready          tdata[187:0] six result fields
//  csr_     in   APB, pready tied high  8 regs at 8*i, 64-bit data
//
// Per word: accept, then 17 multiplies in turn on the shared unit, each as issue, 4 partial
// products, round, done; then the output state, which registers tvalid and the result.
// The result register holds one word; the next request is taken while it waits.
// A result still held at the end of the next word stalls the output cycle.
// Synchronous active-high reset restores config defaults, clears FSM and motor state.
module dq_motor_model_step #(
   parameter int FRAC_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [29:0] voltage_amplitude
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // current_d_out, current_q_out, torque_out,
                                     // motor_speed_out, motor_angle_out, shaft_angle_out
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [63:0] TWO_PI_W = ((dqms_pkg::TWO_PI_Q33 >> (32 - FRAC_BITS)) + 64'd1) >> 1;
   localparam dqms_pkg::s48_type TWO_PI = dqms_pkg::s48_type'(TWO_PI_W[47:0]);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;
   localparam logic [4:0] LAST_STEP = 5'd16;

   logic [1:0] state_ff, state_in;
   logic [4:0] step_ff;

   logic [24:0] time_step_ff, inv_kr_ff;
   logic [46:0] inv_l_ff, inv_j_ff;
   logic [30:0] resist_ff;
   logic [4:0]  pole_ff;
   logic [27:0] flux_ff;
   logic [28:0] load_ff;

   dqms_pkg::s48_type cur_d_ff, cur_q_ff, speed_ff, mang_ff, sang_ff;
   dqms_pkg::s48_type pw_ff, pf_ff, t_ff, did_ff, diq_ff, trq_ff;
   dqms_pkg::s56_type sum_ff;
   logic signed [29:0] amp_ff;

   logic         rsp_valid_ff;
   logic [191:0] rsp_data_ff;

   logic              mul_start, mul_done;
   dqms_pkg::s48_type op_a, op_b, mul_r;
   dqms_pkg::s48_type e_dt, e_inv_l, e_inv_j, e_inv_kr, e_res, e_flux;
   dqms_pkg::s56_type mn_s;
   dqms_pkg::s48_type new_ma, new_sa;
   logic              cfg_wr, in_acc;
   logic [2:0]        cfg_idx;
   logic signed [53:0] pw_prod;

   assign csr_pready = 1'b1;
   assign cfg_wr  = csr_psel & csr_penable & csr_pwrite;
   assign cfg_idx = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= 25'd1678;
         inv_l_ff     <= 47'd74235469680;
         resist_ff    <= 31'd23320330;
         pole_ff      <= 5'd1;
         flux_ff      <= 28'd344268;
         inv_j_ff     <= 47'd8388326143000;
         load_ff      <= 29'd107206;
         inv_kr_ff    <= 25'd162885;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            dqms_pkg::REG_TIME_STEP:  time_step_ff <= csr_pwdata[24:0];
            dqms_pkg::REG_INV_L:      inv_l_ff     <= csr_pwdata[46:0];
            dqms_pkg::REG_RESISTANCE: resist_ff    <= csr_pwdata[30:0];
            dqms_pkg::REG_POLE_PAIRS: pole_ff      <= csr_pwdata[4:0];
            dqms_pkg::REG_FLUX:       flux_ff      <= csr_pwdata[27:0];
            dqms_pkg::REG_INV_J:      inv_j_ff     <= csr_pwdata[46:0];
            dqms_pkg::REG_LOAD:       load_ff      <= csr_pwdata[28:0];
            default:                  inv_kr_ff    <= csr_pwdata[24:0];
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         dqms_pkg::REG_TIME_STEP:  csr_prdata = {39'd0, time_step_ff};
         dqms_pkg::REG_INV_L:      csr_prdata = {17'd0, inv_l_ff};
         dqms_pkg::REG_RESISTANCE: csr_prdata = {33'd0, resist_ff};
         dqms_pkg::REG_POLE_PAIRS: csr_prdata = {59'd0, pole_ff};
         dqms_pkg::REG_FLUX:       csr_prdata = {36'd0, flux_ff};
         dqms_pkg::REG_INV_J:      csr_prdata = {17'd0, inv_j_ff};
         dqms_pkg::REG_LOAD:       csr_prdata = {35'd0, load_ff};
         default:                  csr_prdata = {39'd0, inv_kr_ff};
      endcase
   end

   assign e_dt     = $signed({23'd0, time_step_ff});
   assign e_inv_l  = $signed({1'b0, inv_l_ff});
   assign e_inv_j  = $signed({1'b0, inv_j_ff});
   assign e_inv_kr = $signed({23'd0, inv_kr_ff});
   assign e_res    = $signed({17'd0, resist_ff});
   assign e_flux   = $signed({20'd0, flux_ff});
   assign mn_s     = speed_ff[47] ? -$signed({27'd0, load_ff}) : $signed({27'd0, load_ff});
   assign pw_prod  = $signed({1'b0, pole_ff}) * speed_ff;

   always_comb begin
      case (step_ff)
         5'd0:    begin op_a = e_res;  op_b = cur_d_ff; end
         5'd1:    begin op_a = t_ff;   op_b = e_inv_l;  end
         5'd2:    begin op_a = pw_ff;  op_b = cur_q_ff; end
         5'd3:    begin op_a = e_res;  op_b = cur_q_ff; end
         5'd4:    begin op_a = t_ff;   op_b = e_inv_l;  end
         5'd5:    begin op_a = pw_ff;  op_b = cur_d_ff; end
         5'd6:    begin op_a = -dqms_pkg::s48_type'(amp_ff); op_b = e_inv_l; end
         5'd7:    begin op_a = pw_ff;  op_b = e_flux;   end
         5'd8:    begin op_a = t_ff;   op_b = e_inv_l;  end
         5'd9:    begin op_a = did_ff; op_b = e_dt;     end
         5'd10:   begin op_a = diq_ff; op_b = e_dt;     end
         5'd11:   begin op_a = pf_ff;  op_b = cur_q_ff; end
         5'd12:   begin
            op_a = dqms_pkg::sat48(dqms_pkg::s56_type'(trq_ff) - mn_s);
            op_b = e_dt;
         end
         5'd13:   begin op_a = t_ff;     op_b = e_inv_j;  end
         5'd14:   begin op_a = speed_ff; op_b = e_dt;     end
         5'd15:   begin op_a = speed_ff; op_b = e_inv_kr; end
         default: begin op_a = t_ff;     op_b = e_dt;     end
      endcase
   end

   function automatic dqms_pkg::s48_type wrap(input dqms_pkg::s48_type v);
      dqms_pkg::s48_type r;
      r = v;
      if (r >= TWO_PI)
         r = r - TWO_PI;
      if (r <= -TWO_PI)
         r = r + TWO_PI;
      return r;
   endfunction

   assign new_ma = wrap(dqms_pkg::sat48(dqms_pkg::s56_type'(mang_ff)
                                        + dqms_pkg::s56_type'(mul_r)));
   assign new_sa = wrap(dqms_pkg::sat48(dqms_pkg::s56_type'(sang_ff)
                                        + dqms_pkg::s56_type'(mul_r)));

   assign in_acc     = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign mul_start  = (state_ff == ST_ISSUE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_ISSUE;
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT:  if (mul_done) state_in = (step_ff == LAST_STEP) ? ST_OUT : ST_ISSUE;
         default:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 5'd0;
         rsp_valid_ff <= 1'b0;
         cur_d_ff     <= '0;
         cur_q_ff     <= '0;
         speed_ff     <= '0;
         mang_ff      <= '0;
         sang_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready)
            rsp_valid_ff <= 1'b0;
         if (in_acc)
            step_ff <= 5'd0;
         if (state_ff == ST_WAIT && mul_done) begin
            step_ff <= step_ff + 5'd1;
            case (step_ff)
               5'd9:  cur_d_ff <= dqms_pkg::sat48(dqms_pkg::s56_type'(cur_d_ff)
                                                  + dqms_pkg::s56_type'(mul_r));
               5'd10: cur_q_ff <= dqms_pkg::sat48(dqms_pkg::s56_type'(cur_q_ff)
                                                  + dqms_pkg::s56_type'(mul_r));
               5'd13: speed_ff <= dqms_pkg::sat48(dqms_pkg::s56_type'(speed_ff)
                                                  + dqms_pkg::s56_type'(mul_r));
               5'd14: mang_ff  <= new_ma;
               5'd16: sang_ff  <= new_sa;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         amp_ff <= $signed(req_tdata[29:0]);
         pw_ff  <= dqms_pkg::sat48(dqms_pkg::s56_type'(pw_prod));
         pf_ff  <= $signed({15'd0, 28'(pole_ff) * 33'(flux_ff)});
      end
      if (state_ff == ST_WAIT && mul_done) begin
         case (step_ff)
            5'd0, 5'd3, 5'd7, 5'd12, 5'd15: t_ff <= mul_r;
            5'd1, 5'd4: sum_ff <= -dqms_pkg::s56_type'(mul_r);
            5'd2:  did_ff <= dqms_pkg::sat48(sum_ff + dqms_pkg::s56_type'(mul_r));
            5'd5:  sum_ff <= sum_ff - dqms_pkg::s56_type'(mul_r);
            5'd6:  sum_ff <= sum_ff + dqms_pkg::s56_type'(mul_r);
            5'd8:  diq_ff <= dqms_pkg::sat48(sum_ff - dqms_pkg::s56_type'(mul_r));
            5'd11: trq_ff <= mul_r;
            default: ;
         endcase
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff[31:0]    <= 32'(dqms_pkg::clamp_sym(cur_d_ff, dqms_pkg::CUR_LIM));
         rsp_data_ff[63:32]   <= 32'(dqms_pkg::clamp_sym(cur_q_ff, dqms_pkg::CUR_LIM));
         rsp_data_ff[93:64]   <= 30'(dqms_pkg::clamp_sym(trq_ff, dqms_pkg::TRQ_LIM));
         rsp_data_ff[131:94]  <= 38'(dqms_pkg::clamp_sym(speed_ff, dqms_pkg::SPD_LIM));
         rsp_data_ff[159:132] <= 28'(dqms_pkg::clamp_sym(mang_ff, dqms_pkg::ANG_LIM));
         rsp_data_ff[187:160] <= 28'(dqms_pkg::clamp_sym(sang_ff, dqms_pkg::ANG_LIM));
         rsp_data_ff[191:188] <= 4'd0;
      end
   end

   dqms_mulq #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mulq (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (op_a),
      .b      (op_b),
      .done   (mul_done),
      .result (mul_r)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
